/* src/dwpid_pkg.sv */
// Package for the dual wheel PID controller with coupling.
// Holds payload structs, controller states, command and status types, constants and a 32-bit saturation function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dwpid_pkg;

    localparam int unsigned SpeedMaxDefault   = 255;
    localparam int unsigned ErrorLimitDefault = 4096;

    localparam logic [46:0] Max47 = 47'h7FFF_FFFF_FFFF;

    localparam logic [2:0] RegGainP      = 3'd0;
    localparam logic [2:0] RegGainI      = 3'd1;
    localparam logic [2:0] RegGainD      = 3'd2;
    localparam logic [2:0] RegCoupleP    = 3'd3;
    localparam logic [2:0] RegCoupleI    = 3'd4;
    localparam logic [2:0] RegCoupleD    = 3'd5;
    localparam logic [2:0] RegWheelLimit = 3'd6;
    localparam logic [2:0] RegCoupleLim  = 3'd7;

    localparam logic OpTick  = 1'b0;
    localparam logic OpClear = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] target_left;
        logic signed [31:0] target_right;
        logic signed [31:0] measured_left;
        logic signed [31:0] measured_right;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] command_left;
        logic signed [31:0] command_right;
        logic [7:0]         duty_left;
        logic [7:0]         duty_right;
        logic               reverse_left;
        logic               reverse_right;
        logic               error_fault;
    } out_item_t;

    typedef enum logic [1:0] {
        LOOP_COUPLE = 2'd0,
        LOOP_LEFT   = 2'd1,
        LOOP_RIGHT  = 2'd2
    } loop_sel_t;

    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } term_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAW,
        ST_SETUP,
        ST_MUL,
        ST_ACC,
        ST_FINISH,
        ST_CORR,
        ST_OUT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic      load;
        logic      clear;
        logic      raw;
        logic      setup;
        logic      mul;
        logic      acc;
        logic      finish;
        logic      corr;
        logic      out;
        loop_sel_t loop_sel;
        term_sel_t term_sel;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -36'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/dual_wheel_pid_with_coupling.sv */
// Top level of the dual wheel PID controller with coupling: APB registers and the core.
// Depends on dwpid_pkg, dwpid_ctrl and dwpid_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction runs a coupling PID pass and two wheel PID passes one after another, each
// forming three products on a single 48 by 24 bit multiplier. A finished result waits in an
// output register, so the next transaction is accepted while it is still on offer.
module dual_wheel_pid_with_coupling #(
    parameter int unsigned SPEED_MAX   = dwpid_pkg::SpeedMaxDefault,
    parameter int unsigned ERROR_LIMIT = dwpid_pkg::ErrorLimitDefault
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  dwpid_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output dwpid_pkg::out_item_t m_data,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [5:0]           paddr,
    input  wire  [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    logic [23:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [23:0] couple_p_reg, couple_i_reg, couple_d_reg;
    logic [46:0] wheel_lim_reg, couple_lim_reg;
    logic [2:0]  idx;
    logic        wr;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite && (paddr[2:0] == 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= '0; gain_i_reg <= '0; gain_d_reg <= '0;
            couple_p_reg <= '0; couple_i_reg <= '0; couple_d_reg <= '0;
            wheel_lim_reg  <= dwpid_pkg::Max47;
            couple_lim_reg <= dwpid_pkg::Max47;
        end else if (wr) begin
            case (idx)
                dwpid_pkg::RegGainP:      gain_p_reg     <= pwdata[23:0];
                dwpid_pkg::RegGainI:      gain_i_reg     <= pwdata[23:0];
                dwpid_pkg::RegGainD:      gain_d_reg     <= pwdata[23:0];
                dwpid_pkg::RegCoupleP:    couple_p_reg   <= pwdata[23:0];
                dwpid_pkg::RegCoupleI:    couple_i_reg   <= pwdata[23:0];
                dwpid_pkg::RegCoupleD:    couple_d_reg   <= pwdata[23:0];
                dwpid_pkg::RegWheelLimit: wheel_lim_reg  <= pwdata[46:0];
                dwpid_pkg::RegCoupleLim:  couple_lim_reg <= pwdata[46:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            dwpid_pkg::RegGainP:      prdata = 64'(gain_p_reg);
            dwpid_pkg::RegGainI:      prdata = 64'(gain_i_reg);
            dwpid_pkg::RegGainD:      prdata = 64'(gain_d_reg);
            dwpid_pkg::RegCoupleP:    prdata = 64'(couple_p_reg);
            dwpid_pkg::RegCoupleI:    prdata = 64'(couple_i_reg);
            dwpid_pkg::RegCoupleD:    prdata = 64'(couple_d_reg);
            dwpid_pkg::RegWheelLimit: prdata = 64'(wheel_lim_reg);
            default:                  prdata = 64'(couple_lim_reg);
        endcase
    end

    dwpid_pkg::cmd_t    cmd;
    dwpid_pkg::status_t status;

    dwpid_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dwpid_datapath #(
        .SPEED_MAX   (SPEED_MAX),
        .ERROR_LIMIT (ERROR_LIMIT)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .in_item          (s_data),
        .gain_p           (gain_p_reg),
        .gain_i           (gain_i_reg),
        .gain_d           (gain_d_reg),
        .couple_p         (couple_p_reg),
        .couple_i         (couple_i_reg),
        .couple_d         (couple_d_reg),
        .wheel_sum_limit  (wheel_lim_reg),
        .couple_sum_limit (couple_lim_reg),
        .out_item         (m_data)
    );

    a_duty_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.duty_left <= 8'(SPEED_MAX > 255 ? 255 : SPEED_MAX)))
        else $error("duty above speed maximum");

    a_reverse_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.reverse_left == m_data.command_left[31]))
        else $error("reverse flag disagrees with command sign");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while busy");

endmodule
`default_nettype wire

/* src/dwpid_datapath.sv */
// Datapath of the dual wheel PID controller: state, shared multiplier, accumulator.
// Depends on dwpid_pkg; driven by dwpid_ctrl through a command struct.
`timescale 1ns / 1ps
`default_nettype none
module dwpid_datapath #(
    parameter int unsigned SPEED_MAX   = dwpid_pkg::SpeedMaxDefault,
    parameter int unsigned ERROR_LIMIT = dwpid_pkg::ErrorLimitDefault
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  dwpid_pkg::cmd_t      cmd,
    output dwpid_pkg::status_t   status,
    input  dwpid_pkg::in_item_t  in_item,
    input  wire  [23:0]          gain_p,
    input  wire  [23:0]          gain_i,
    input  wire  [23:0]          gain_d,
    input  wire  [23:0]          couple_p,
    input  wire  [23:0]          couple_i,
    input  wire  [23:0]          couple_d,
    input  wire  [46:0]          wheel_sum_limit,
    input  wire  [46:0]          couple_sum_limit,
    output dwpid_pkg::out_item_t out_item
);

    localparam logic [7:0] DutyMax = (SPEED_MAX > 255) ? 8'd255 : 8'(SPEED_MAX);
    localparam logic signed [32:0] ErrLimit = 33'(ERROR_LIMIT);
    localparam logic [63:0] ProdLim = 64'h2000_0000_0000_0000;

    dwpid_pkg::in_item_t in_reg;
    logic signed [31:0] prev_l_reg, prev_r_reg, prev_c_reg;
    logic signed [47:0] sum_l_reg, sum_r_reg, sum_c_reg;
    logic signed [31:0] el_reg, er_reg, ec_reg;
    logic signed [31:0] corr_reg;
    logic signed [31:0] cmd_l_reg, cmd_r_reg;
    logic [47:0] mag_reg;
    logic        neg_reg;
    logic [23:0] g_reg;
    logic [71:0] prod_reg;
    logic        pneg_reg;
    logic signed [63:0] acc_reg;
    dwpid_pkg::out_item_t out_reg;

    logic signed [31:0] e_sel, prev_sel;
    logic signed [47:0] sum_sel, sum_new;
    logic [46:0]        lim_sel;
    logic [23:0]        gi_sel;
    logic signed [48:0] sum_raw, lim_s;
    logic signed [48:0] opnd;
    logic [23:0]        g_sel;
    logic [63:0]        psat;
    logic [63:0]        amag;
    logic [47:0]        q;
    logic signed [48:0] qs;
    logic signed [31:0] pid_res;

    always_comb begin
        case (cmd.loop_sel)
            dwpid_pkg::LOOP_LEFT: begin
                e_sel = el_reg; prev_sel = prev_l_reg; sum_sel = sum_l_reg;
                lim_sel = wheel_sum_limit; gi_sel = gain_i;
            end
            dwpid_pkg::LOOP_RIGHT: begin
                e_sel = er_reg; prev_sel = prev_r_reg; sum_sel = sum_r_reg;
                lim_sel = wheel_sum_limit; gi_sel = gain_i;
            end
            default: begin
                e_sel = ec_reg; prev_sel = prev_c_reg; sum_sel = sum_c_reg;
                lim_sel = couple_sum_limit; gi_sel = couple_i;
            end
        endcase
        sum_raw = 49'(sum_sel) + 49'(e_sel);
        lim_s   = (gi_sel != 24'd0) ? 49'({2'b00, lim_sel}) : 49'({2'b00, dwpid_pkg::Max47});
        if (sum_raw <= -lim_s) begin
            sum_new = 48'(-lim_s);
        end else if (sum_raw >= lim_s) begin
            sum_new = 48'(lim_s);
        end else begin
            sum_new = 48'(sum_raw);
        end
        case (cmd.term_sel)
            dwpid_pkg::TERM_I: opnd = 49'(sum_new);
            dwpid_pkg::TERM_D: opnd = 49'(e_sel) - 49'(prev_sel);
            default:           opnd = 49'(e_sel);
        endcase
        if (cmd.loop_sel == dwpid_pkg::LOOP_COUPLE) begin
            case (cmd.term_sel)
                dwpid_pkg::TERM_I: g_sel = couple_i;
                dwpid_pkg::TERM_D: g_sel = couple_d;
                default:           g_sel = couple_p;
            endcase
        end else begin
            case (cmd.term_sel)
                dwpid_pkg::TERM_I: g_sel = gain_i;
                dwpid_pkg::TERM_D: g_sel = gain_d;
                default:           g_sel = gain_p;
            endcase
        end
        psat = (prod_reg > 72'(ProdLim)) ? ProdLim : prod_reg[63:0];
        amag = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        q    = amag[63:16];
        qs   = acc_reg[63] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (qs > 49'sd2147483647) begin
            pid_res = 32'sh7FFF_FFFF;
        end else if (qs < -49'sd2147483648) begin
            pid_res = 32'sh8000_0000;
        end else begin
            pid_res = qs[31:0];
        end
    end

    function automatic logic [7:0] duty_of(input logic signed [31:0] c);
        logic [31:0] m;
        m = c[31] ? 32'(-c) : 32'(c);
        return (m > 32'(DutyMax)) ? DutyMax : m[7:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= in_item;
        end
        if (cmd.raw) begin
            el_reg <= dwpid_pkg::sat32(36'(in_reg.target_left) - 36'(in_reg.measured_left));
            er_reg <= dwpid_pkg::sat32(36'(in_reg.target_right) - 36'(in_reg.measured_right));
        end
        if (cmd.corr) begin
            el_reg <= dwpid_pkg::sat32(36'(in_reg.target_left) + 36'(corr_reg)
                                       - 36'(in_reg.measured_left));
            er_reg <= dwpid_pkg::sat32(36'(in_reg.target_right) - 36'(corr_reg)
                                       - 36'(in_reg.measured_right));
        end
        if (cmd.setup && cmd.loop_sel == dwpid_pkg::LOOP_COUPLE) begin
            ec_reg <= dwpid_pkg::sat32(36'(el_reg) - 36'(er_reg));
        end
        if (cmd.mul) begin
            neg_reg <= opnd[48];
            mag_reg <= opnd[48] ? 48'(-opnd) : 48'(opnd);
            g_reg   <= g_sel;
        end
        if (cmd.acc) begin
            pneg_reg <= neg_reg;
            prod_reg <= 72'(mag_reg) * 72'(g_reg);
        end
        if (cmd.finish) begin
            case (cmd.loop_sel)
                dwpid_pkg::LOOP_LEFT:  cmd_l_reg <= pid_res;
                dwpid_pkg::LOOP_RIGHT: cmd_r_reg <= pid_res;
                default:               corr_reg  <= pid_res;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            prev_l_reg <= '0; prev_r_reg <= '0; prev_c_reg <= '0;
            sum_l_reg  <= '0; sum_r_reg  <= '0; sum_c_reg  <= '0;
        end else if (cmd.out && in_reg.op == dwpid_pkg::OpTick) begin
            prev_l_reg <= el_reg;
            prev_r_reg <= er_reg;
            prev_c_reg <= ec_reg;
        end else if (cmd.finish) begin
            case (cmd.loop_sel)
                dwpid_pkg::LOOP_LEFT:  sum_l_reg <= sum_new;
                dwpid_pkg::LOOP_RIGHT: sum_r_reg <= sum_new;
                default:               sum_c_reg <= sum_new;
            endcase
        end
    end

    logic        add_pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_pend_reg <= 1'b0;
        end else begin
            add_pend_reg <= cmd.acc;
        end
    end

    logic signed [63:0] acc_next;
    always_comb begin
        acc_next = acc_reg;
        if (cmd.setup) begin
            acc_next = '0;
        end else if (add_pend_reg) begin
            acc_next = pneg_reg ? acc_reg - $signed(psat) : acc_reg + $signed(psat);
        end
    end

    // Accumulator: the product of the previous term is added while the next multiplies.
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign status.is_clear = in_reg.op;

    always_ff @(posedge aclk) begin
        if (cmd.out) begin
            if (in_reg.op == dwpid_pkg::OpClear) begin
                out_reg <= '0;
            end else begin
                out_reg.command_left  <= cmd_l_reg;
                out_reg.command_right <= cmd_r_reg;
                out_reg.duty_left     <= duty_of(cmd_l_reg);
                out_reg.duty_right    <= duty_of(cmd_r_reg);
                out_reg.reverse_left  <= cmd_l_reg[31];
                out_reg.reverse_right <= cmd_r_reg[31];
                out_reg.error_fault   <= (33'(el_reg) >= ErrLimit) ||
                                         (33'(er_reg) >= ErrLimit);
            end
        end
    end

    assign out_item = out_reg;

endmodule
`default_nettype wire

/* src/dwpid_ctrl.sv */
// Controller of the dual wheel PID: sequences three PID passes over the shared multiplier.
// Depends on dwpid_pkg; drives dwpid_datapath through a command struct.
`timescale 1ns / 1ps
`default_nettype none
module dwpid_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire                out_ready,
    input  dwpid_pkg::status_t status,
    output dwpid_pkg::cmd_t    cmd
);

    dwpid_pkg::state_t    state_reg, state_next;
    dwpid_pkg::loop_sel_t loop_reg, loop_next;
    dwpid_pkg::term_sel_t term_reg, term_next;
    logic                 valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dwpid_pkg::ST_IDLE;
            loop_reg  <= dwpid_pkg::LOOP_COUPLE;
            term_reg  <= dwpid_pkg::TERM_P;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            loop_reg  <= loop_next;
            term_reg  <= term_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        loop_next  = loop_reg;
        term_next  = term_reg;
        valid_next = valid_reg;
        cmd        = '0;
        cmd.loop_sel = loop_reg;
        cmd.term_sel = term_reg;
        in_ready   = 1'b0;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            dwpid_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = dwpid_pkg::ST_RAW;
                end
            end
            dwpid_pkg::ST_RAW: begin
                if (status.is_clear) begin
                    cmd.clear  = 1'b1;
                    state_next = dwpid_pkg::ST_OUT;
                end else begin
                    cmd.raw    = 1'b1;
                    loop_next  = dwpid_pkg::LOOP_COUPLE;
                    state_next = dwpid_pkg::ST_SETUP;
                end
            end
            dwpid_pkg::ST_SETUP: begin
                cmd.setup  = 1'b1;
                term_next  = dwpid_pkg::TERM_P;
                state_next = dwpid_pkg::ST_MUL;
            end
            dwpid_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = dwpid_pkg::ST_ACC;
            end
            dwpid_pkg::ST_ACC: begin
                cmd.acc = 1'b1;
                if (term_reg == dwpid_pkg::TERM_D) begin
                    state_next = dwpid_pkg::ST_HOLD;
                end else begin
                    term_next  = (term_reg == dwpid_pkg::TERM_P) ? dwpid_pkg::TERM_I
                                                                  : dwpid_pkg::TERM_D;
                    state_next = dwpid_pkg::ST_MUL;
                end
            end
            dwpid_pkg::ST_HOLD: begin
                state_next = dwpid_pkg::ST_FINISH;
            end
            dwpid_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                case (loop_reg)
                    dwpid_pkg::LOOP_COUPLE: state_next = dwpid_pkg::ST_CORR;
                    dwpid_pkg::LOOP_LEFT: begin
                        loop_next  = dwpid_pkg::LOOP_RIGHT;
                        state_next = dwpid_pkg::ST_SETUP;
                    end
                    default: state_next = dwpid_pkg::ST_OUT;
                endcase
            end
            dwpid_pkg::ST_CORR: begin
                cmd.corr   = 1'b1;
                loop_next  = dwpid_pkg::LOOP_LEFT;
                state_next = dwpid_pkg::ST_SETUP;
            end
            dwpid_pkg::ST_OUT: begin
                if (!valid_reg || out_ready) begin
                    cmd.out    = 1'b1;
                    valid_next = 1'b1;
                    state_next = dwpid_pkg::ST_IDLE;
                end
            end
            default: state_next = dwpid_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = valid_reg;

endmodule
`default_nettype wire
